// ----- design/jnp_pkg.sv -----
// jnp_pkg: types, constants and helpers for the json number parser
// no dependencies; used by every module of the block
package jnp_pkg;

  localparam int QDepth = 2;

  localparam logic [62:0] Mag63Max = {63{1'b1}};
  localparam logic [63:0] MagMax   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MagMinBits = 64'h8000_0000_0000_0000;
  localparam logic [31:0] CntMax   = 32'hFFFF_FFFF;
  // largest value that can still take one more digit of at most 7
  localparam logic [62:0] LimBase  = 63'd922337203685477580;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] integer_part;
    logic signed [63:0] exponent_out;
    logic [62:0]        fraction_out;
    logic [31:0]        fraction_digits;
    logic               invalid;
    logic               precision_loss;
    logic               positive_overflow;
    logic               negative_overflow;
    logic               positive_infinity;
    logic               negative_infinity;
  } out_item_t;

  // classified character handed from front to back
  typedef struct packed {
    logic       is_end;
    logic       is_digit;
    logic       is_dot;
    logic       is_ee;
    logic       is_minus;
    logic       is_plus;
    logic [3:0] digit;
  } cls_t;

  typedef enum logic [9:0] {
    P_START = 10'b00_0000_0001,
    P_MINUS = 10'b00_0000_0010,
    P_ZERO  = 10'b00_0000_0100,
    P_INT   = 10'b00_0000_1000,
    P_DOT   = 10'b00_0001_0000,
    P_FRAC  = 10'b00_0010_0000,
    P_EXPM  = 10'b00_0100_0000,
    P_EXPS  = 10'b00_1000_0000,
    P_EXPD  = 10'b01_0000_0000,
    P_ERR   = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [6:0] {
    C_RUN   = 7'b000_0001,
    C_FLUSH = 7'b000_0010,
    C_FIN   = 7'b000_0100,
    C_MUL   = 7'b000_1000,
    C_DIV   = 7'b001_0000,
    C_INT   = 7'b010_0000,
    C_EMIT  = 7'b100_0000
  } ctl_e;

  // (max - d) / 10 for a digit d
  function automatic logic [62:0] digit_lim(input logic [3:0] d);
    return (d > 4'd7) ? (LimBase - 63'd1) : LimBase;
  endfunction

  function automatic logic [62:0] times_ten(input logic [62:0] x, input logic [3:0] d);
    return (x << 3) + (x << 1) + {59'd0, d};
  endfunction

endpackage

// ----- design/jnp_front.sv -----
// jnp_front: takes input items, classifies each character and queues it
// depends on jnp_pkg
module jnp_front #(
  parameter int Depth = jnp_pkg::QDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jnp_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output jnp_pkg::cls_t     q_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jnp_pkg::cls_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  jnp_pkg::cls_t cls;
  logic push, pop;

  always_comb begin
    cls          = '0;
    cls.is_end   = in_item_i.is_end;
    cls.is_digit = (in_item_i.ch >= 8'h30) && (in_item_i.ch <= 8'h39);
    cls.digit    = cls.is_digit ? in_item_i.ch[3:0] : 4'd0;
    cls.is_dot   = (in_item_i.ch == 8'h2E);
    cls.is_ee    = (in_item_i.ch == 8'h65) || (in_item_i.ch == 8'h45);
    cls.is_minus = (in_item_i.ch == 8'h2D);
    cls.is_plus  = (in_item_i.ch == 8'h2B);
  end

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/jnp_back.sv -----
// jnp_back: parser state, end-of-number evaluation and output register
// depends on jnp_pkg
module jnp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  jnp_pkg::cls_t      q_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jnp_pkg::out_item_t out_item_o
);

  jnp_pkg::ctl_e   ctl_q, ctl_d;
  jnp_pkg::phase_e phase_q, phase_d;
  logic neg_q, neg_d, expneg_q, expneg_d;
  logic [62:0] int_q, int_d, shift_q, shift_d, exp_q, exp_d, frac_q, frac_d;
  logic [31:0] cnt_q, cnt_d, pend_q, pend_d;
  logic loss_q, loss_d, expovf_q, expovf_d, shiftsat_q, shiftsat_d, skip_q, skip_d;
  logic [3:0] pdig_q, pdig_d;
  logic signed [63:0] e_q, e_d;
  logic [63:0] mag_q, mag_d;
  logic povf_q, povf_d, novf_q, novf_d;
  logic [63:0] quo_q, quo_d;
  logic [1:0] dcnt_q, dcnt_d;
  jnp_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  jnp_pkg::cls_t c;
  jnp_pkg::phase_e next;
  logic [33:0] csum;
  logic [63:0] sum64;
  logic signed [63:0] e;
  logic up, down, loss, fin_ok;
  jnp_pkg::out_item_t res;
  logic [63:0] tmp;
  logic [63:0] diff;

  assign c = q_item_i;

  always_comb begin
    ctl_d = ctl_q; phase_d = phase_q; neg_d = neg_q; expneg_d = expneg_q;
    int_d = int_q; shift_d = shift_q; exp_d = exp_q; frac_d = frac_q;
    cnt_d = cnt_q; pend_d = pend_q; loss_d = loss_q; expovf_d = expovf_q;
    shiftsat_d = shiftsat_q; skip_d = skip_q; pdig_d = pdig_q;
    e_d = e_q; mag_d = mag_q; povf_d = povf_q; novf_d = novf_q;
    quo_d = quo_q; dcnt_d = dcnt_q; res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o = 1'b0;
    next = jnp_pkg::P_ERR;
    csum = '0; sum64 = '0; e = '0; up = 1'b0; down = 1'b0; loss = 1'b0;
    fin_ok = 1'b0; res = '0; tmp = '0; diff = '0;

    unique case (ctl_q)
      jnp_pkg::C_RUN: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (c.is_end) begin
            ctl_d = jnp_pkg::C_FIN;
          end else begin
            unique case (phase_q)
              jnp_pkg::P_START, jnp_pkg::P_MINUS, jnp_pkg::P_INT: begin
                if (phase_q == jnp_pkg::P_START && c.is_minus) begin
                  neg_d = 1'b1;
                  next  = jnp_pkg::P_MINUS;
                end else if (phase_q != jnp_pkg::P_INT && c.is_digit && c.digit == 4'd0) begin
                  next = jnp_pkg::P_ZERO;
                end else if (c.is_digit) begin
                  next = jnp_pkg::P_INT;
                  if (shift_q != '0) begin
                    if (shift_q != jnp_pkg::Mag63Max) shift_d = shift_q + 63'd1;
                    else shiftsat_d = 1'b1;
                  end else if (int_q > jnp_pkg::digit_lim(c.digit)) begin
                    shift_d = 63'd1;
                  end else begin
                    int_d = jnp_pkg::times_ten(int_q, c.digit);
                  end
                end else if (phase_q == jnp_pkg::P_INT && c.is_dot) begin
                  next = jnp_pkg::P_DOT;
                end else if (phase_q == jnp_pkg::P_INT && c.is_ee) begin
                  next = jnp_pkg::P_EXPM;
                end
              end
              jnp_pkg::P_ZERO: begin
                if (c.is_dot) next = jnp_pkg::P_DOT;
                else if (c.is_ee) next = jnp_pkg::P_EXPM;
              end
              jnp_pkg::P_DOT, jnp_pkg::P_FRAC: begin
                if (c.is_digit) begin
                  next = jnp_pkg::P_FRAC;
                  if (!skip_q) begin
                    if (c.digit == 4'd0) begin
                      if (pend_q != jnp_pkg::CntMax) pend_d = pend_q + 32'd1;
                    end else begin
                      if (pend_q == jnp_pkg::CntMax) loss_d = 1'b1;
                      if (frac_q == '0) begin
                        csum = {2'b00, cnt_q} + {2'b00, pend_q} + 34'd1;
                        if (csum > {2'b00, jnp_pkg::CntMax}) begin
                          cnt_d  = jnp_pkg::CntMax;
                          loss_d = 1'b1;
                        end else begin
                          cnt_d = csum[31:0];
                        end
                        pend_d = '0;
                        frac_d = {59'd0, c.digit};
                      end else if (pend_q != '0) begin
                        pdig_d = c.digit;
                        ctl_d  = jnp_pkg::C_FLUSH;
                      end else if (frac_q > jnp_pkg::digit_lim(c.digit)) begin
                        skip_d = 1'b1;
                        loss_d = 1'b1;
                      end else begin
                        frac_d = jnp_pkg::times_ten(frac_q, c.digit);
                        if (cnt_q == jnp_pkg::CntMax) loss_d = 1'b1;
                        else cnt_d = cnt_q + 32'd1;
                      end
                    end
                  end
                end else if (c.is_ee && phase_q == jnp_pkg::P_FRAC) begin
                  next = jnp_pkg::P_EXPM;
                end
              end
              jnp_pkg::P_EXPM, jnp_pkg::P_EXPS, jnp_pkg::P_EXPD: begin
                if (phase_q == jnp_pkg::P_EXPM && c.is_minus) begin
                  expneg_d = 1'b1;
                  next     = jnp_pkg::P_EXPS;
                end else if (phase_q == jnp_pkg::P_EXPM && c.is_plus) begin
                  next = jnp_pkg::P_EXPS;
                end else if (c.is_digit) begin
                  next = jnp_pkg::P_EXPD;
                  if (!expovf_q) begin
                    if (exp_q > jnp_pkg::digit_lim(c.digit)) expovf_d = 1'b1;
                    else exp_d = jnp_pkg::times_ten(exp_q, c.digit);
                  end
                end
              end
              default: ;
            endcase
            phase_d = next;
          end
        end
      end

      jnp_pkg::C_FLUSH: begin
        if (pend_q == '0) begin
          ctl_d = jnp_pkg::C_RUN;
          if (frac_q > jnp_pkg::digit_lim(pdig_q)) begin
            skip_d = 1'b1;
            loss_d = 1'b1;
          end else begin
            frac_d = jnp_pkg::times_ten(frac_q, pdig_q);
            if (cnt_q == jnp_pkg::CntMax) loss_d = 1'b1;
            else cnt_d = cnt_q + 32'd1;
          end
        end else if (frac_q > jnp_pkg::LimBase) begin
          skip_d = 1'b1;
          loss_d = 1'b1;
          ctl_d  = jnp_pkg::C_RUN;
        end else begin
          frac_d = jnp_pkg::times_ten(frac_q, 4'd0);
          pend_d = pend_q - 32'd1;
          if (cnt_q == jnp_pkg::CntMax) loss_d = 1'b1;
          else cnt_d = cnt_q + 32'd1;
        end
      end

      jnp_pkg::C_FIN: begin
        fin_ok = (phase_q == jnp_pkg::P_ZERO) || (phase_q == jnp_pkg::P_INT) ||
                 (phase_q == jnp_pkg::P_FRAC) || (phase_q == jnp_pkg::P_EXPD);
        ctl_d = jnp_pkg::C_EMIT;
        loss  = loss_q;
        sum64 = {1'b0, shift_q} + {1'b0, exp_q};
        if (expovf_q) begin
          down = expneg_q;
          up   = !expneg_q;
        end else if (shiftsat_q) begin
          up = 1'b1;
        end else if (!expneg_q) begin
          up = sum64[63];
          e  = sum64;
        end else begin
          e = $signed({1'b0, shift_q}) - $signed({1'b0, exp_q});
        end
        if (!fin_ok) begin
          res.invalid = 1'b1;
        end else if (int_q == '0 && frac_q == '0) begin
          res = '0;
        end else if (up) begin
          res.positive_infinity = !neg_q;
          res.negative_infinity = neg_q;
          res.integer_part = neg_q ? jnp_pkg::MagMinBits : jnp_pkg::MagMax;
          if (mode_i) begin
            res.exponent_out    = jnp_pkg::MagMax;
            res.fraction_out    = frac_q;
            res.fraction_digits = cnt_q;
          end else begin
            if (frac_q != '0) loss = 1'b1;
            res.positive_overflow = !neg_q;
            res.negative_overflow = neg_q;
          end
          res.precision_loss = loss;
        end else if (down) begin
          if (mode_i && frac_q != '0) begin
            res.exponent_out    = jnp_pkg::MagMinBits;
            res.fraction_out    = frac_q;
            res.fraction_digits = cnt_q;
          end
          res.precision_loss = 1'b1;
        end else begin
          if (int_q == '0 && (!mode_i || frac_q == '0)) begin
            e = '0;
            if (frac_q != '0) loss = 1'b1;
          end
          if (mode_i) begin
            res.integer_part    = neg_q ? -{1'b0, int_q} : {1'b0, int_q};
            res.exponent_out    = e;
            res.fraction_out    = frac_q;
            res.fraction_digits = cnt_q;
            res.precision_loss  = loss;
          end else begin
            if (frac_q != '0) loss = 1'b1;
            loss_d = loss;
            mag_d  = {1'b0, int_q};
            e_d    = e;
            povf_d = 1'b0;
            novf_d = 1'b0;
            dcnt_d = '0;
            if (int_q != '0 && e > 0) ctl_d = jnp_pkg::C_MUL;
            else if (int_q != '0 && e < 0) ctl_d = jnp_pkg::C_DIV;
            else ctl_d = jnp_pkg::C_INT;
          end
        end
        res_d = res;
      end

      jnp_pkg::C_MUL: begin
        if (e_q == '0) begin
          ctl_d = jnp_pkg::C_INT;
        end else if (mag_q > {1'b0, jnp_pkg::LimBase}) begin
          povf_d = !neg_q;
          novf_d = neg_q;
          ctl_d  = jnp_pkg::C_INT;
        end else begin
          mag_d = (mag_q << 3) + (mag_q << 1);
          e_d   = e_q - 64'sd1;
        end
      end

      // divide by ten with shift-add reciprocal, then correct the quotient from the remainder
      jnp_pkg::C_DIV: begin
        unique case (dcnt_q)
          2'd0: begin
            if (e_q == '0 || mag_q == '0) begin
              ctl_d = jnp_pkg::C_INT;
            end else begin
              tmp    = (mag_q >> 1) + (mag_q >> 2);
              quo_d  = tmp + (tmp >> 4);
              dcnt_d = 2'd1;
            end
          end
          2'd1: begin
            tmp    = quo_q + (quo_q >> 8);
            quo_d  = tmp + (tmp >> 16);
            dcnt_d = 2'd2;
          end
          2'd2: begin
            tmp    = quo_q + (quo_q >> 32);
            quo_d  = tmp >> 3;
            dcnt_d = 2'd3;
          end
          2'd3: begin
            diff  = mag_q - ((quo_q << 3) + (quo_q << 1));
            mag_d = (diff > 64'd9) ? (quo_q + 64'd1) : quo_q;
            if (diff != 64'd0 && diff != 64'd10) loss_d = 1'b1;
            e_d    = e_q + 64'sd1;
            dcnt_d = 2'd0;
          end
        endcase
      end

      jnp_pkg::C_INT: begin
        res = '0;
        if (povf_q) res.integer_part = jnp_pkg::MagMax;
        else if (novf_q) res.integer_part = jnp_pkg::MagMinBits;
        else res.integer_part = neg_q ? -mag_q : mag_q;
        res.precision_loss    = loss_q;
        res.positive_overflow = povf_q;
        res.negative_overflow = novf_q;
        res_d = res;
        ctl_d = jnp_pkg::C_EMIT;
      end

      jnp_pkg::C_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          ctl_d       = jnp_pkg::C_RUN;
          phase_d = jnp_pkg::P_START; neg_d = 1'b0; expneg_d = 1'b0;
          int_d = '0; shift_d = '0; exp_d = '0; frac_d = '0; cnt_d = '0;
          pend_d = '0; loss_d = 1'b0; expovf_d = 1'b0; shiftsat_d = 1'b0;
          skip_d = 1'b0;
        end
      end

      default: ctl_d = jnp_pkg::C_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= jnp_pkg::C_RUN; phase_q <= jnp_pkg::P_START;
      neg_q <= 1'b0; expneg_q <= 1'b0;
      int_q <= '0; shift_q <= '0; exp_q <= '0; frac_q <= '0;
      cnt_q <= '0; pend_q <= '0; loss_q <= 1'b0; expovf_q <= 1'b0;
      shiftsat_q <= 1'b0; skip_q <= 1'b0; out_valid_q <= 1'b0;
      dcnt_q <= '0; povf_q <= 1'b0; novf_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d; phase_q <= phase_d; neg_q <= neg_d; expneg_q <= expneg_d;
      int_q <= int_d; shift_q <= shift_d; exp_q <= exp_d; frac_q <= frac_d;
      cnt_q <= cnt_d; pend_q <= pend_d; loss_q <= loss_d; expovf_q <= expovf_d;
      shiftsat_q <= shiftsat_d; skip_q <= skip_d; out_valid_q <= out_valid_d;
      dcnt_q <= dcnt_d; povf_q <= povf_d; novf_q <= novf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pdig_q <= pdig_d;
    e_q    <= e_d;
    mag_q  <= mag_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- design/json_number_parser_unit.sv -----
// json_number_parser_unit: top level of the json number parser
// depends on jnp_pkg, jnp_front and jnp_back
//
// channel  | handshake              | payload
// in       | in_valid_i/in_ready_o  | in_item_i (ch, is_end)
// out      | out_valid_o/out_ready_i| out_item_o (one per end item)
// config   | cfg_we_i               | cfg_wdata_i (mode)
//
// a character item is handled in the back end as it is popped; a nonzero fraction
// digit after held zeros first appends them one by one in the flush state, at most
// about twenty; an end item passes the finish and emit states, and in integer mode
// up to twenty multiply or up to twenty divide-by-ten steps and an integer state
// the front queue keeps taking items until full while the back end is busy or stalled on out
// reset clears the parser control and accumulator state and sets mode to integer
module json_number_parser_unit #(
  parameter int QueueDepth = jnp_pkg::QDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jnp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jnp_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);

  logic mode_q;
  logic q_valid, q_pop;
  jnp_pkg::cls_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  jnp_front #(.Depth(QueueDepth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  jnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
